// ----- src/rgb_block_pool_downscaler_assert.svh -----
// Assertion macros for the block pool downscaler.
// Used by the top level; expects i_clk and i_rst_n in scope.
`ifndef RGB_BLOCK_POOL_DOWNSCALER_ASSERT_SVH
`define RGB_BLOCK_POOL_DOWNSCALER_ASSERT_SVH

// same-cycle implication
`define RGBPD_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// next-cycle implication
`define RGBPD_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

// ----- src/rgbpd_pkg.sv -----
// Shared types, constants and glyph table for the block pool downscaler.
// No dependencies.
package rgbpd_pkg;

    // frame and block limits; the widths below are sized for these
    localparam int MAX_WIDTH = 2048;
    localparam int MAX_BLOCK = 16;

    localparam int CH_W   = 8;
    localparam int ACC_W  = 16;
    localparam int BLK_W  = 5;
    localparam int SRC_W  = 12;
    localparam int POS_W  = 11;
    localparam int AREA_W = 2 * BLK_W;
    localparam int CFG_W  = 12;
    localparam int IDX_W  = 3;

    localparam logic [IDX_W-1:0] REG_BLOCK_WIDTH   = 3'd0;
    localparam logic [IDX_W-1:0] REG_BLOCK_HEIGHT  = 3'd1;
    localparam logic [IDX_W-1:0] REG_SOURCE_WIDTH  = 3'd2;
    localparam logic [IDX_W-1:0] REG_SOURCE_HEIGHT = 3'd3;
    localparam logic [IDX_W-1:0] REG_POOL_MODE     = 3'd4;
    localparam logic [IDX_W-1:0] REG_GRAY_ENABLE   = 3'd5;
    localparam logic [IDX_W-1:0] REG_GLYPH_ENABLE  = 3'd6;

    // luma = (2126 R + 7152 G + 722 B) / 10000, done as ((s >> 4) * M) >> 27, M = 2^27/625 up
    localparam int LUMA_KR    = 2126;
    localparam int LUMA_KG    = 7152;
    localparam int LUMA_KB    = 722;
    localparam int WSUM_W     = 22;
    localparam int RECIP_M    = 214749;
    localparam int RECIP_W    = 18;
    localparam int RECIP_SH   = 27;
    localparam int PROD_W     = 36;
    localparam int GLYPH_LAST = 27;

    typedef logic [2:0][ACC_W-1:0] t_acc3;
    typedef logic [2:0][CH_W-1:0]  t_px3;

    function automatic logic [6:0] glyph_char(input logic [4:0] idx);
        logic [6:0] ch;
        case (idx) inside
            [5'd0:5'd2]:   ch = 7'd32;  // space
            [5'd3:5'd5]:   ch = 7'd46;  // .
            [5'd6:5'd8]:   ch = 7'd58;  // :
            [5'd9:5'd11]:  ch = 7'd45;  // -
            [5'd12:5'd14]: ch = 7'd61;  // =
            [5'd15:5'd17]: ch = 7'd43;  // +
            [5'd18:5'd19]: ch = 7'd34;  // "
            [5'd20:5'd21]: ch = 7'd94;  // ^
            [5'd22:5'd23]: ch = 7'd42;  // *
            [5'd24:5'd25]: ch = 7'd35;  // #
            default:       ch = 7'd64;  // @
        endcase
        return ch;
    endfunction

endpackage

// ----- src/rgbpd_ram.sv -----
// Generic single-write, single-read synchronous RAM, registered read.
// No dependencies.
module rgbpd_ram #(
    parameter int WIDTH = 48,
    parameter int DEPTH = 2048
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ----- src/rgbpd_div.sv -----
// Three-lane restoring divider, one quotient bit per cycle.
// Depends on rgbpd_pkg.
module rgbpd_div #(
    parameter int DIV_W = 10
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_start,
    input  rgbpd_pkg::t_acc3     i_dividend,
    input  logic [DIV_W-1:0]     i_divisor,
    output logic                 o_done,
    output rgbpd_pkg::t_acc3     o_quot
);

    localparam int QW  = rgbpd_pkg::ACC_W;
    localparam int CNT_W = $clog2(QW);

    rgbpd_pkg::t_acc3           r_q;
    logic [2:0][DIV_W-1:0]      r_rem;
    logic [DIV_W-1:0]           r_div;
    logic [CNT_W-1:0]           r_cnt;
    logic                       r_busy;
    logic                       r_done;
    rgbpd_pkg::t_acc3           n_q;
    logic [2:0][DIV_W-1:0]      n_rem;

    always_comb begin
        logic [DIV_W:0] sh;
        for (int c = 0; c < 3; c++) begin
            sh = {r_rem[c], r_q[c][QW-1]};
            if (sh >= {1'b0, r_div}) begin
                n_rem[c] = DIV_W'(sh - {1'b0, r_div});
                n_q[c]   = {r_q[c][QW-2:0], 1'b1};
            end else begin
                n_rem[c] = sh[DIV_W-1:0];
                n_q[c]   = {r_q[c][QW-2:0], 1'b0};
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == CNT_W'(QW - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_q   <= i_dividend;
            r_rem <= '0;
            r_div <= i_divisor;
        end else if (r_busy) begin
            r_q   <= n_q;
            r_rem <= n_rem;
        end
    end

    assign o_done = r_done;
    assign o_quot = r_q;

endmodule

// ----- src/rgb_block_pool_downscaler.sv -----
// Block pool downscaler: one column accumulator per output column in a RAM.
// A pixel that closes no block goes through S_IDLE (accumulator read) and S_RMW (write-back).
// A block's last pixel goes on to S_LUMA1, S_LUMA2 and S_OUT, with S_DIV (16-step divider)
// first in average mode; input is taken while a result waits in the output beat.
// Reset (synchronous, active low) clears the counters and the output valid, loads the config
// defaults; the accumulator RAM is not cleared, the first pixel of each block loads it.
`include "rgb_block_pool_downscaler_assert.svh"
module rgb_block_pool_downscaler #(
    parameter int GLYPH_COUNT = 26
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_index,
    input  logic [11:0] i_cfg_data,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [7:0]  i_red,
    input  logic [7:0]  i_green,
    input  logic [7:0]  i_blue,
    input  logic        i_frame_start,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [7:0]  o_out_red,
    output logic [7:0]  o_out_green,
    output logic [7:0]  o_out_blue,
    output logic [6:0]  o_glyph_code,
    output logic [10:0] o_out_column,
    output logic [10:0] o_out_line,
    output logic        o_end_of_line,
    output logic        o_end_of_frame
);

    localparam int MAX_WIDTH = rgbpd_pkg::MAX_WIDTH;
    localparam int MAX_BLOCK = rgbpd_pkg::MAX_BLOCK;
    localparam int AW    = $clog2(MAX_WIDTH);
    localparam int BLK_W = rgbpd_pkg::BLK_W;
    localparam int SRC_W = rgbpd_pkg::SRC_W;
    localparam int POS_W = rgbpd_pkg::POS_W;
    localparam int ACC_W = rgbpd_pkg::ACC_W;
    localparam int MUL_W = SRC_W + BLK_W;
    localparam int GP_W  = 8 + $clog2(GLYPH_COUNT + 1);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_RMW   = 3'd1;
    localparam logic [2:0] S_DIV   = 3'd2;
    localparam logic [2:0] S_LUMA1 = 3'd3;
    localparam logic [2:0] S_LUMA2 = 3'd4;
    localparam logic [2:0] S_OUT   = 3'd5;

    // configuration
    logic [BLK_W-1:0] r_bw, r_bh;
    logic [SRC_W-1:0] r_sw, r_sh;
    logic             r_pool, r_gray, r_glyph;

    // position counters
    logic [POS_W-1:0] r_src_x, r_src_y, r_bc, r_br;
    logic [BLK_W-1:0] r_ibx, r_iby;

    logic [2:0] r_state;

    // beat captured at accept
    rgbpd_pkg::t_px3          r_pix;
    logic                     r_hit, r_first, r_last, r_eol, r_eof;
    logic [POS_W-1:0]         r_col, r_row;
    logic [AW-1:0]            r_addr;
    logic [rgbpd_pkg::AREA_W-1:0] r_area;

    // result path
    rgbpd_pkg::t_px3                r_val;
    logic [rgbpd_pkg::WSUM_W-1:0]   r_wsum;
    logic [rgbpd_pkg::PROD_W-1:0]   r_prod;

    // output beat
    logic        r_out_valid;
    logic [7:0]  r_out_r, r_out_g, r_out_b;
    logic [6:0]  r_out_glyph;
    logic [10:0] r_out_col, r_out_row;
    logic        r_out_eol, r_out_eof;

    logic accept;
    assign o_in_ready = (r_state == S_IDLE);
    assign accept     = i_in_valid && o_in_ready;

    // effective register values
    logic [BLK_W-1:0] bw_e, bh_e;
    logic [SRC_W-1:0] sw_e, sh_e;
    always_comb begin
        bw_e = (r_bw == '0) ? BLK_W'(1) : (32'(r_bw) > MAX_BLOCK) ? BLK_W'(MAX_BLOCK) : r_bw;
        bh_e = (r_bh == '0) ? BLK_W'(1) : (32'(r_bh) > MAX_BLOCK) ? BLK_W'(MAX_BLOCK) : r_bh;
        sw_e = (r_sw == '0) ? SRC_W'(1) : (32'(r_sw) > MAX_WIDTH) ? SRC_W'(MAX_WIDTH) : r_sw;
        sh_e = (r_sh == '0) ? SRC_W'(1) : (32'(r_sh) > MAX_WIDTH) ? SRC_W'(MAX_WIDTH) : r_sh;
    end

    // counters after an optional frame_start clear
    logic [POS_W-1:0] cx, cy, cbc, cbr;
    logic [BLK_W-1:0] cibx, ciby;
    assign cx   = i_frame_start ? '0 : r_src_x;
    assign cy   = i_frame_start ? '0 : r_src_y;
    assign cbc  = i_frame_start ? '0 : r_bc;
    assign cbr  = i_frame_start ? '0 : r_br;
    assign cibx = i_frame_start ? '0 : r_ibx;
    assign ciby = i_frame_start ? '0 : r_iby;

    // block c lies inside the frame iff (c+1)*bw <= sw; it is the last iff also (c+2)*bw > sw
    logic [MUL_W-1:0] col_end, row_end;
    logic             in_col, in_row, last_col, last_row;
    always_comb begin
        col_end  = MUL_W'({1'b0, cbc} + 1'b1) * MUL_W'(bw_e);
        row_end  = MUL_W'({1'b0, cbr} + 1'b1) * MUL_W'(bh_e);
        in_col   = (col_end <= MUL_W'(sw_e)) && (32'(cbc) < MAX_WIDTH);
        in_row   = (row_end <= MUL_W'(sh_e));
        last_col = (col_end + MUL_W'(bw_e)) > MUL_W'(sw_e);
        last_row = (row_end + MUL_W'(bh_e)) > MUL_W'(sh_e);
    end

    // next counter values
    logic [POS_W-1:0] n_src_x, n_src_y, n_bc, n_br;
    logic [BLK_W-1:0] n_ibx, n_iby;
    always_comb begin
        n_src_x = cx;
        n_src_y = cy;
        n_bc    = cbc;
        n_br    = cbr;
        n_ibx   = cibx;
        n_iby   = ciby;
        if ({1'b0, cx} + 1'b1 >= sw_e) begin
            n_src_x = '0;
            n_ibx   = '0;
            n_bc    = '0;
            if ({1'b0, cy} + 1'b1 >= sh_e) begin
                n_src_y = '0;
                n_iby   = '0;
                n_br    = '0;
            end else begin
                n_src_y = cy + 1'b1;
                if ({1'b0, ciby} + 1'b1 >= {1'b0, bh_e}) begin
                    n_iby = '0;
                    n_br  = cbr + 1'b1;
                end else begin
                    n_iby = ciby + 1'b1;
                end
            end
        end else begin
            n_src_x = cx + 1'b1;
            if ({1'b0, cibx} + 1'b1 >= {1'b0, bw_e}) begin
                n_ibx = '0;
                n_bc  = cbc + 1'b1;
            end else begin
                n_ibx = cibx + 1'b1;
            end
        end
    end

    // accumulator RAM: read at accept, write back in S_RMW
    logic [3*ACC_W-1:0] ram_rdata, ram_wdata;
    logic               ram_we;
    rgbpd_pkg::t_acc3   acc_old, acc_new;

    assign acc_old   = ram_rdata;
    assign ram_wdata = acc_new;
    assign ram_we    = (r_state == S_RMW) && r_hit;

    always_comb begin
        for (int c = 0; c < 3; c++) begin
            if (r_first) begin
                acc_new[c] = ACC_W'(r_pix[c]);
            end else if (r_pool) begin
                acc_new[c] = acc_old[c] + ACC_W'(r_pix[c]);
            end else begin
                acc_new[c] = (ACC_W'(r_pix[c]) > acc_old[c]) ? ACC_W'(r_pix[c]) : acc_old[c];
            end
        end
    end

    rgbpd_ram #(
        .WIDTH(3 * ACC_W),
        .DEPTH(MAX_WIDTH)
    ) u_acc_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (r_addr),
        .i_wdata (ram_wdata),
        .i_re    (accept),
        .i_raddr (AW'(cbc)),
        .o_rdata (ram_rdata)
    );

    // averaging divider, started on a block's last pixel
    logic             div_start, div_done;
    rgbpd_pkg::t_acc3 div_quot;
    assign div_start = (r_state == S_RMW) && r_hit && r_last && r_pool;

    rgbpd_div #(
        .DIV_W(rgbpd_pkg::AREA_W)
    ) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (acc_new),
        .i_divisor  (r_area),
        .o_done     (div_done),
        .o_quot     (div_quot)
    );

    // glyph from luma
    logic [8:0]      luma;
    logic [GP_W-1:0] gprod;
    logic [GP_W-9:0] gidx;
    logic [4:0]      gsel;
    logic            gray_on;
    assign gray_on = r_gray || r_glyph;
    assign luma    = r_prod[rgbpd_pkg::RECIP_SH +: 9];
    always_comb begin
        gprod = GP_W'(luma) * GP_W'(GLYPH_COUNT);
        gidx  = gprod[GP_W-1:8];
        gsel  = (32'(gidx) > rgbpd_pkg::GLYPH_LAST) ? 5'(rgbpd_pkg::GLYPH_LAST) : 5'(gidx);
    end

    logic out_free;
    assign out_free = !r_out_valid || i_out_ready;

    // control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
            r_src_x     <= '0;
            r_src_y     <= '0;
            r_bc        <= '0;
            r_br        <= '0;
            r_ibx       <= '0;
            r_iby       <= '0;
            r_bw        <= BLK_W'(5);
            r_bh        <= BLK_W'(10);
            r_sw        <= SRC_W'(640);
            r_sh        <= SRC_W'(480);
            r_pool      <= 1'b0;
            r_gray      <= 1'b1;
            r_glyph     <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_index)
                    rgbpd_pkg::REG_BLOCK_WIDTH:   r_bw    <= i_cfg_data[BLK_W-1:0];
                    rgbpd_pkg::REG_BLOCK_HEIGHT:  r_bh    <= i_cfg_data[BLK_W-1:0];
                    rgbpd_pkg::REG_SOURCE_WIDTH:  r_sw    <= i_cfg_data;
                    rgbpd_pkg::REG_SOURCE_HEIGHT: r_sh    <= i_cfg_data;
                    rgbpd_pkg::REG_POOL_MODE:     r_pool  <= i_cfg_data[0];
                    rgbpd_pkg::REG_GRAY_ENABLE:   r_gray  <= i_cfg_data[0];
                    rgbpd_pkg::REG_GLYPH_ENABLE:  r_glyph <= i_cfg_data[0];
                    default: ;
                endcase
            end
            if (r_out_valid && i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            if (accept) begin
                r_src_x <= n_src_x;
                r_src_y <= n_src_y;
                r_bc    <= n_bc;
                r_br    <= n_br;
                r_ibx   <= n_ibx;
                r_iby   <= n_iby;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (accept) begin
                        r_state <= S_RMW;
                    end
                end
                S_RMW: begin
                    if (r_hit && r_last) begin
                        r_state <= r_pool ? S_DIV : S_LUMA1;
                    end else begin
                        r_state <= S_IDLE;
                    end
                end
                S_DIV: begin
                    if (div_done) begin
                        r_state <= S_LUMA1;
                    end
                end
                S_LUMA1: r_state <= S_LUMA2;
                S_LUMA2: r_state <= S_OUT;
                S_OUT: begin
                    if (out_free) begin
                        r_out_valid <= 1'b1;
                        r_state     <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    // datapath
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_pix   <= {i_blue, i_green, i_red};
            r_hit   <= in_col && in_row;
            r_first <= (cibx == '0) && (ciby == '0);
            r_last  <= (cibx == bw_e - 1'b1) && (ciby == bh_e - 1'b1);
            r_col   <= cbc;
            r_row   <= cbr;
            r_eol   <= last_col;
            r_eof   <= last_col && last_row;
            r_addr  <= AW'(cbc);
            r_area  <= rgbpd_pkg::AREA_W'(bw_e) * rgbpd_pkg::AREA_W'(bh_e);
        end
        if (r_state == S_RMW) begin
            for (int c = 0; c < 3; c++) begin
                r_val[c] <= (acc_new[c] > ACC_W'(255)) ? 8'd255 : acc_new[c][7:0];
            end
        end
        if (r_state == S_DIV && div_done) begin
            for (int c = 0; c < 3; c++) begin
                r_val[c] <= (div_quot[c] > ACC_W'(255)) ? 8'd255 : div_quot[c][7:0];
            end
        end
        if (r_state == S_LUMA1) begin
            r_wsum <= rgbpd_pkg::WSUM_W'(r_val[0]) * rgbpd_pkg::WSUM_W'(rgbpd_pkg::LUMA_KR)
                    + rgbpd_pkg::WSUM_W'(r_val[1]) * rgbpd_pkg::WSUM_W'(rgbpd_pkg::LUMA_KG)
                    + rgbpd_pkg::WSUM_W'(r_val[2]) * rgbpd_pkg::WSUM_W'(rgbpd_pkg::LUMA_KB);
        end
        if (r_state == S_LUMA2) begin
            // divide by 10000: drop 4 bits, then reciprocal of 625
            r_prod <= rgbpd_pkg::PROD_W'(r_wsum[rgbpd_pkg::WSUM_W-1:4])
                    * rgbpd_pkg::PROD_W'(rgbpd_pkg::RECIP_M);
        end
        if (r_state == S_OUT && out_free) begin
            r_out_r     <= gray_on ? luma[7:0] : r_val[0];
            r_out_g     <= gray_on ? luma[7:0] : r_val[1];
            r_out_b     <= gray_on ? luma[7:0] : r_val[2];
            r_out_glyph <= r_glyph ? rgbpd_pkg::glyph_char(gsel) : 7'd0;
            r_out_col   <= r_col;
            r_out_row   <= r_row;
            r_out_eol   <= r_eol;
            r_out_eof   <= r_eof;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_out_red      = r_out_r;
    assign o_out_green    = r_out_g;
    assign o_out_blue     = r_out_b;
    assign o_glyph_code   = r_out_glyph;
    assign o_out_column   = r_out_col;
    assign o_out_line     = r_out_row;
    assign o_end_of_line  = r_out_eol;
    assign o_end_of_frame = r_out_eof;

    // every accepted beat gets its read-modify-write next cycle
    `RGBPD_ASSERT_NEXT(a_accept_rmw, accept, r_state == S_RMW)
    // divider only finishes while the sequencer waits for it
    `RGBPD_ASSERT_NOW(a_div_done_state, div_done, r_state == S_DIV)
    // a finished result is always loaded into the output beat
    `RGBPD_ASSERT_NEXT(a_out_load, (r_state == S_OUT) && out_free, r_out_valid)

endmodule
